// ----- rtl/motor_drive_fault_monitor_defines.svh -----
// Assertion helpers for the fault monitor checkers.
// Both expect signals named clk and arst_n in the scope of use.
`ifndef MOTOR_DRIVE_FAULT_MONITOR_DEFINES_SVH
`define MOTOR_DRIVE_FAULT_MONITOR_DEFINES_SVH

// Same-cycle implication.
`define MDFM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MDFM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mdfm_pkg.sv -----
package mdfm_pkg;

	// Field widths
	localparam int unsigned FUNC_W   = 3;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned LIM_W    = 15;
	localparam int unsigned FRAC_W   = 12;
	localparam int unsigned CYC_W    = 16;
	localparam int unsigned CNT_W    = 17;
	localparam int unsigned FLAG_W   = 6;
	localparam int unsigned CIDX_W   = 3;
	localparam int unsigned CDATA_W  = 16;

	// Item function codes
	typedef enum logic [FUNC_W-1:0] {
		FUNC_PHASE = 3'd0,
		FUNC_BUS   = 3'd1,
		FUNC_HEAT  = 3'd2,
		FUNC_HW    = 3'd3,
		FUNC_FAN   = 3'd4,
		FUNC_CLEAR = 3'd5
	} func_t;

	// Configuration register indexes
	typedef enum logic [CIDX_W-1:0] {
		CFG_WARN_RATIO    = 3'd0,
		CFG_CURRENT_LIMIT = 3'd1,
		CFG_WARN_CYCLES   = 3'd2,
		CFG_BUS_HIGH      = 3'd3,
		CFG_BUS_LOW       = 3'd4,
		CFG_TEMP_LIMIT    = 3'd5,
		CFG_FAN_ON_FRAC   = 3'd6,
		CFG_FAN_OFF_FRAC  = 3'd7
	} cfg_idx_t;

	// Fault flag bit positions
	localparam int unsigned FLAG_AVG  = 0;
	localparam int unsigned FLAG_MAX  = 1;
	localparam int unsigned FLAG_OV   = 2;
	localparam int unsigned FLAG_UV   = 3;
	localparam int unsigned FLAG_HEAT = 4;
	localparam int unsigned FLAG_HW   = 5;

	// Register reset values
	localparam logic [FRAC_W-1:0] RST_WARN_RATIO    = 12'd3686;
	localparam logic [LIM_W-1:0]  RST_CURRENT_LIMIT = 15'd8192;
	localparam logic [CYC_W-1:0]  RST_WARN_CYCLES   = 16'd100;
	localparam logic [LIM_W-1:0]  RST_BUS_HIGH      = 15'd4915;
	localparam logic [LIM_W-1:0]  RST_BUS_LOW       = 15'd3277;
	localparam logic [LIM_W-1:0]  RST_TEMP_LIMIT    = 15'd4096;
	localparam logic [FRAC_W-1:0] RST_FAN_ON_FRAC   = 12'd3277;
	localparam logic [FRAC_W-1:0] RST_FAN_OFF_FRAC  = 12'd2867;

	// Derived thresholds at reset: (frac * limit) >> 12
	localparam logic [LIM_W-1:0] RST_WARN_THR =
		LIM_W'((int'(RST_WARN_RATIO) * int'(RST_CURRENT_LIMIT)) / (2 ** FRAC_W));
	localparam logic [LIM_W-1:0] RST_FAN_ON_THR =
		LIM_W'((int'(RST_FAN_ON_FRAC) * int'(RST_TEMP_LIMIT)) / (2 ** FRAC_W));
	localparam logic [LIM_W-1:0] RST_FAN_OFF_THR =
		LIM_W'((int'(RST_FAN_OFF_FRAC) * int'(RST_TEMP_LIMIT)) / (2 ** FRAC_W));

	// Limits as seen by the check logic
	typedef struct packed {
		logic [LIM_W-1:0] warn_thr;
		logic [LIM_W-1:0] current_limit;
		logic [CYC_W-1:0] warn_cycles;
		logic [LIM_W-1:0] bus_high_limit;
		logic [LIM_W-1:0] bus_low_limit;
		logic [LIM_W-1:0] temp_limit;
		logic [LIM_W-1:0] fan_on_thr;
		logic [LIM_W-1:0] fan_off_thr;
	} limits_t;

endpackage

// ----- rtl/mdfm_ifs.sv -----
// Input item channel
interface mdfm_item_if;
	logic                                 valid;
	logic                                 ready;
	logic [mdfm_pkg::FUNC_W-1:0]          func;
	logic signed [mdfm_pkg::SAMPLE_W-1:0] phase_a;
	logic signed [mdfm_pkg::SAMPLE_W-1:0] phase_b;
	logic signed [mdfm_pkg::SAMPLE_W-1:0] phase_c;
	logic signed [mdfm_pkg::SAMPLE_W-1:0] bus_voltage;
	logic signed [mdfm_pkg::SAMPLE_W-1:0] temperature;
	logic                                 healthy;

	modport source (output valid, func, phase_a, phase_b, phase_c, bus_voltage,
		temperature, healthy, input ready);
	modport sink (input valid, func, phase_a, phase_b, phase_c, bus_voltage,
		temperature, healthy, output ready);
endinterface

// Result channel
interface mdfm_result_if;
	logic                        valid;
	logic                        ready;
	logic                        tripped;
	logic [mdfm_pkg::FLAG_W-1:0] fault_flags;
	logic                        fan_on;

	modport source (output valid, tripped, fault_flags, fan_on, input ready);
	modport sink (input valid, tripped, fault_flags, fan_on, output ready);
endinterface

// Configuration write channel
interface mdfm_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [mdfm_pkg::CIDX_W-1:0]  index;
	logic [mdfm_pkg::CDATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/mdfm_cfg.sv -----
// Register file plus the registered fraction-times-limit thresholds.
module mdfm_cfg (
	input  logic              clk,
	input  logic              arst_n,
	mdfm_cfg_if.sink          cfg,
	output mdfm_pkg::limits_t limits
);

	logic [mdfm_pkg::FRAC_W-1:0] warn_ratio_q, fan_on_frac_q, fan_off_frac_q;
	logic [mdfm_pkg::LIM_W-1:0]  current_limit_q, bus_high_q, bus_low_q, temp_limit_q;
	logic [mdfm_pkg::CYC_W-1:0]  warn_cycles_q;
	logic [mdfm_pkg::LIM_W-1:0]  warn_thr_q, fan_on_thr_q, fan_off_thr_q;

	logic [mdfm_pkg::FRAC_W-1:0] warn_ratio_n, fan_on_frac_n, fan_off_frac_n;
	logic [mdfm_pkg::LIM_W-1:0]  current_limit_n, temp_limit_n;
	logic [mdfm_pkg::FRAC_W+mdfm_pkg::LIM_W-1:0] warn_prod, fan_on_prod, fan_off_prod;
	logic                        wr;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid;

	// Next values of the multiplier operands, so thresholds track a write at once
	always_comb begin
		warn_ratio_n    = warn_ratio_q;
		current_limit_n = current_limit_q;
		temp_limit_n    = temp_limit_q;
		fan_on_frac_n   = fan_on_frac_q;
		fan_off_frac_n  = fan_off_frac_q;
		if (wr) begin
			case (cfg.index)
				mdfm_pkg::CFG_WARN_RATIO:    warn_ratio_n    = cfg.data[mdfm_pkg::FRAC_W-1:0];
				mdfm_pkg::CFG_CURRENT_LIMIT: current_limit_n = cfg.data[mdfm_pkg::LIM_W-1:0];
				mdfm_pkg::CFG_TEMP_LIMIT:    temp_limit_n    = cfg.data[mdfm_pkg::LIM_W-1:0];
				mdfm_pkg::CFG_FAN_ON_FRAC:   fan_on_frac_n   = cfg.data[mdfm_pkg::FRAC_W-1:0];
				mdfm_pkg::CFG_FAN_OFF_FRAC:  fan_off_frac_n  = cfg.data[mdfm_pkg::FRAC_W-1:0];
				default: ;
			endcase
		end
	end

	// Q0.12 x Q3.12, keep the Q3.12 part
	assign warn_prod    = warn_ratio_n * current_limit_n;
	assign fan_on_prod  = fan_on_frac_n * temp_limit_n;
	assign fan_off_prod = fan_off_frac_n * temp_limit_n;

	// Register file and thresholds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warn_ratio_q    <= mdfm_pkg::RST_WARN_RATIO;
			current_limit_q <= mdfm_pkg::RST_CURRENT_LIMIT;
			warn_cycles_q   <= mdfm_pkg::RST_WARN_CYCLES;
			bus_high_q      <= mdfm_pkg::RST_BUS_HIGH;
			bus_low_q       <= mdfm_pkg::RST_BUS_LOW;
			temp_limit_q    <= mdfm_pkg::RST_TEMP_LIMIT;
			fan_on_frac_q   <= mdfm_pkg::RST_FAN_ON_FRAC;
			fan_off_frac_q  <= mdfm_pkg::RST_FAN_OFF_FRAC;
			warn_thr_q      <= mdfm_pkg::RST_WARN_THR;
			fan_on_thr_q    <= mdfm_pkg::RST_FAN_ON_THR;
			fan_off_thr_q   <= mdfm_pkg::RST_FAN_OFF_THR;
		end else begin
			warn_ratio_q    <= warn_ratio_n;
			current_limit_q <= current_limit_n;
			temp_limit_q    <= temp_limit_n;
			fan_on_frac_q   <= fan_on_frac_n;
			fan_off_frac_q  <= fan_off_frac_n;
			warn_thr_q      <= warn_prod[mdfm_pkg::FRAC_W +: mdfm_pkg::LIM_W];
			fan_on_thr_q    <= fan_on_prod[mdfm_pkg::FRAC_W +: mdfm_pkg::LIM_W];
			fan_off_thr_q   <= fan_off_prod[mdfm_pkg::FRAC_W +: mdfm_pkg::LIM_W];
			if (wr) begin
				case (cfg.index)
					mdfm_pkg::CFG_WARN_CYCLES: warn_cycles_q <= cfg.data;
					mdfm_pkg::CFG_BUS_HIGH:    bus_high_q    <= cfg.data[mdfm_pkg::LIM_W-1:0];
					mdfm_pkg::CFG_BUS_LOW:     bus_low_q     <= cfg.data[mdfm_pkg::LIM_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		limits.warn_thr       = warn_thr_q;
		limits.current_limit  = current_limit_q;
		limits.warn_cycles    = warn_cycles_q;
		limits.bus_high_limit = bus_high_q;
		limits.bus_low_limit  = bus_low_q;
		limits.temp_limit     = temp_limit_q;
		limits.fan_on_thr     = fan_on_thr_q;
		limits.fan_off_thr    = fan_off_thr_q;
	end

endmodule

// ----- rtl/motor_drive_fault_monitor.sv -----
// Motor drive fault monitor.
// item:   one check per beat, selected by func (phase currents, bus voltage,
//         overheat, hardware health, fan, clear).
// result: one beat per item: tripped, the sticky fault_flags and fan_on.
// cfg:    register writes, always ready; the user must write while no item is
// in flight, which the block does not enforce. An accepted item is held in the
// input register, and its result is loaded into the output register once that
// register is free; it is valid from then on and is taken when the receiver is
// ready.
// Throughput: one item per cycle while the receiver does not stall; the flag,
// warning counter and fan state update in the single check stage, so each item sees its predecessor's state.
// Reset clears the flags, counter, fan state and both valid bits; registers
// return to their default limits.
// When the receiver stalls, the result register holds its beat, the input
// register still takes one more item, and item.ready then drops until the
// result beat is taken.
module motor_drive_fault_monitor (
	input  logic           clk,
	input  logic           arst_n,
	mdfm_item_if.sink      item,
	mdfm_result_if.source  result,
	mdfm_cfg_if.sink       cfg
);

	mdfm_pkg::limits_t limits;

	mdfm_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.limits (limits)
	);

	// Saturating magnitude of a Q3.12 sample
	function automatic logic [mdfm_pkg::LIM_W-1:0] sat_abs(
		input logic [mdfm_pkg::SAMPLE_W-1:0] x
	);
		logic [mdfm_pkg::SAMPLE_W-1:0] neg;
		neg = '0 - x;
		if (!x[mdfm_pkg::SAMPLE_W-1])
			return x[mdfm_pkg::LIM_W-1:0];
		else if (neg[mdfm_pkg::SAMPLE_W-1])
			return '1;
		else
			return neg[mdfm_pkg::LIM_W-1:0];
	endfunction

	// Input register
	logic                            valid_s1;
	logic [mdfm_pkg::FUNC_W-1:0]     func_s1;
	logic [mdfm_pkg::SAMPLE_W-1:0]   pa_s1, pb_s1, pc_s1, bus_s1, temp_s1;
	logic                            healthy_s1;

	// Output register
	logic                            res_valid_q;
	logic                            tripped_q;
	logic [mdfm_pkg::FLAG_W-1:0]     flags_out_q;
	logic                            fan_out_q;

	// Monitor state
	logic [mdfm_pkg::FLAG_W-1:0]     flags_q, flags_n;
	logic [mdfm_pkg::CNT_W-1:0]      warn_count_q, warn_count_n, cnt_inc;
	logic                            fan_q, fan_n;
	logic                            trip_n;

	logic                            out_free, adv, in_acc;
	logic [mdfm_pkg::LIM_W-1:0]      abs_a, abs_b, abs_c;
	logic                            any_warn, any_max;
	logic signed [mdfm_pkg::SAMPLE_W:0] bus_x, temp_x;

	// Handshake
	assign out_free   = !res_valid_q || result.ready;
	assign adv        = valid_s1 && out_free;
	assign item.ready = !valid_s1 || out_free;
	assign in_acc     = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (item.ready)
			valid_s1 <= item.valid;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1    <= item.func;
			pa_s1      <= item.phase_a;
			pb_s1      <= item.phase_b;
			pc_s1      <= item.phase_c;
			bus_s1     <= item.bus_voltage;
			temp_s1    <= item.temperature;
			healthy_s1 <= item.healthy;
		end
	end

	// Magnitudes and threshold compares
	always_comb begin
		abs_a    = sat_abs(pa_s1);
		abs_b    = sat_abs(pb_s1);
		abs_c    = sat_abs(pc_s1);
		any_warn = (abs_a > limits.warn_thr) || (abs_b > limits.warn_thr) ||
			(abs_c > limits.warn_thr);
		any_max  = (abs_a > limits.current_limit) || (abs_b > limits.current_limit) ||
			(abs_c > limits.current_limit);
		bus_x    = {bus_s1[mdfm_pkg::SAMPLE_W-1], bus_s1};
		temp_x   = {temp_s1[mdfm_pkg::SAMPLE_W-1], temp_s1};
		cnt_inc  = warn_count_q + 1'b1;
	end

	// Check logic and next state
	always_comb begin
		flags_n      = flags_q;
		warn_count_n = warn_count_q;
		fan_n        = fan_q;
		trip_n       = 1'b0;
		case (func_s1)
			mdfm_pkg::FUNC_PHASE: begin
				if (any_warn) begin
					if (cnt_inc > {1'b0, limits.warn_cycles}) begin
						flags_n[mdfm_pkg::FLAG_AVG] = 1'b1;
						warn_count_n = '0;
					end else begin
						warn_count_n = cnt_inc;
					end
				end else begin
					warn_count_n = '0;
				end
				if (any_max)
					flags_n[mdfm_pkg::FLAG_MAX] = 1'b1;
				trip_n = flags_n[mdfm_pkg::FLAG_AVG] || flags_n[mdfm_pkg::FLAG_MAX];
			end
			mdfm_pkg::FUNC_BUS: begin
				if (bus_x > $signed({2'b00, limits.bus_high_limit}))
					flags_n[mdfm_pkg::FLAG_OV] = 1'b1;
				if (bus_x < $signed({2'b00, limits.bus_low_limit}))
					flags_n[mdfm_pkg::FLAG_UV] = 1'b1;
				trip_n = flags_n[mdfm_pkg::FLAG_OV] || flags_n[mdfm_pkg::FLAG_UV];
			end
			mdfm_pkg::FUNC_HEAT: begin
				if (temp_x > $signed({2'b00, limits.temp_limit}))
					flags_n[mdfm_pkg::FLAG_HEAT] = 1'b1;
				trip_n = flags_n[mdfm_pkg::FLAG_HEAT];
			end
			mdfm_pkg::FUNC_HW: begin
				if (!healthy_s1)
					flags_n[mdfm_pkg::FLAG_HW] = 1'b1;
			end
			mdfm_pkg::FUNC_FAN: begin
				// hysteresis: on above upper threshold, off below lower one
				if (temp_x > $signed({2'b00, limits.fan_on_thr}))
					fan_n = 1'b1;
				else if (temp_x < $signed({2'b00, limits.fan_off_thr}))
					fan_n = 1'b0;
				trip_n = fan_n;
			end
			mdfm_pkg::FUNC_CLEAR: begin
				flags_n      = '0;
				warn_count_n = '0;
			end
			default: ;
		endcase
	end

	// State and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q      <= '0;
			warn_count_q <= '0;
			fan_q        <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (adv) begin
				flags_q      <= flags_n;
				warn_count_q <= warn_count_n;
				fan_q        <= fan_n;
			end
			if (out_free)
				res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tripped_q   <= trip_n;
			flags_out_q <= flags_n;
			fan_out_q   <= fan_n;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.tripped     = tripped_q;
	assign result.fault_flags = flags_out_q;
	assign result.fan_on      = fan_out_q;

endmodule

// ----- rtl/mdfm_checker.sv -----
`include "motor_drive_fault_monitor_defines.svh"

// Port-level checks for the fault monitor.
module mdfm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        item_valid,
	input logic                        item_ready,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic                        res_tripped,
	input logic [mdfm_pkg::FLAG_W-1:0] res_flags,
	input logic                        res_fan_on
);

	logic       in_acc, out_acc;
	logic [1:0] inflight_q;

	assign in_acc  = item_valid && item_ready;
	assign out_acc = res_valid && res_ready;

	// Items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_q <= '0;
		else
			inflight_q <= inflight_q + {1'b0, in_acc} - {1'b0, out_acc};
	end

	`MDFM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
		res_valid && $stable({res_tripped, res_flags, res_fan_on}),
		"stalled result beat changed")
	`MDFM_ASSERT_SAME(a_no_invented, res_valid, inflight_q != 2'd0,
		"result beat without an accepted item")
	`MDFM_ASSERT_SAME(a_full_stalls, inflight_q == 2'd2 && !res_ready, !item_ready,
		"item taken while both stages are held")
	`MDFM_ASSERT_SAME(a_trip_cause, res_valid && res_tripped,
		res_flags != '0 || res_fan_on,
		"trip reported with no flag and fan off")

endmodule

bind motor_drive_fault_monitor mdfm_checker u_mdfm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item.valid),
	.item_ready  (item.ready),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_tripped (result.tripped),
	.res_flags   (result.fault_flags),
	.res_fan_on  (result.fan_on)
);
